[design/lap_pkg.sv]
package lap_pkg;

    // Sample and frame geometry.
    localparam int PIXEL_BITS   = 16;
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
    localparam int DIM_BITS     = 12;
    localparam int LAP_BITS     = 19;
    localparam int CFG_BITS     = 12;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                         cmd;
        logic signed [PIXEL_BITS-1:0] pixel_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [LAP_BITS-1:0] laplace_value;
        logic [COL_BITS-1:0]        column;
        logic [ROW_BITS-1:0]        row;
        logic                       frame_end;
    } t_out_beat;

    // Read request to the line stores: center column address.
    typedef struct packed {
        logic                en;
        logic [COL_BITS-1:0] addr;
    } t_ls_rd;

    // Write request: the new pixel goes to the newer row, the old center to the older row.
    typedef struct packed {
        logic                  we;
        logic [COL_BITS-1:0]   addr;
        logic [PIXEL_BITS-1:0] newer;
        logic [PIXEL_BITS-1:0] older;
    } t_ls_wr;

endpackage

[design/lap_line_store.sv]
module lap_line_store (
    input  logic                            i_clk,
    input  lap_pkg::t_ls_rd                 i_rd,
    input  lap_pkg::t_ls_wr                 i_wr,
    output logic [lap_pkg::PIXEL_BITS-1:0]  o_center,
    output logic [lap_pkg::PIXEL_BITS-1:0]  o_right,
    output logic [lap_pkg::PIXEL_BITS-1:0]  o_up
);
    import lap_pkg::*;

    logic [PIXEL_BITS-1:0] r_newer [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_older [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] r_center;
    logic [PIXEL_BITS-1:0] r_right;
    logic [PIXEL_BITS-1:0] r_up;
    logic [COL_BITS-1:0]   rd_addr_next;

    assign rd_addr_next = i_rd.addr + COL_BITS'(1);

    // Newer row: one write port, two read ports (center and right neighbor).
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_newer[i_wr.addr] <= i_wr.newer;
        end
        if (i_rd.en) begin
            r_center <= r_newer[i_rd.addr];
            r_right  <= r_newer[rd_addr_next];
        end
    end

    // Older row: one write port, one read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_older[i_wr.addr] <= i_wr.older;
        end
        if (i_rd.en) begin
            r_up <= r_older[i_rd.addr];
        end
    end

    assign o_center = r_center;
    assign o_right  = r_right;
    assign o_up     = r_up;

endmodule

[design/laplacian_filter_mirrored_borders_unit.sv]
// Four-neighbor Laplacian over a raster-order pixel stream with mirrored borders.
// Input channel: i_in_valid / o_in_stall carry one beat per pixel (cmd = pixel) or
// one drain request (cmd = drain). The result for row y-1, column x leaves on the
// output channel (o_out_valid / i_out_stall) after the pixel of row y, column x is
// taken; after the last pixel of a frame one drain beat per column flushes the
// last row. Row 0 pixels and drains with nothing pending give no result beat.
// The line store is read at the edge that takes the beat; the sum, formed from
// the stage-1 registers and the read data, is registered in the output register.
// Throughput is one beat per cycle while a stalled receiver does not hold the
// compute stage: the read of the next beat overlaps the write-back of the current
// one, and a same-column collision is resolved by forwarding the value just
// written. Configuration (width, height) is written through i_cfg_we; the user
// must write it only while the unit is idle, which the block does not enforce.
// Reset (i_rst_n low, synchronous) clears the counters, the pipeline and the
// output valid, and restores 640 x 480; the line stores keep their contents and
// need no clearing pass. When the receiver stalls, the result waits in the
// output register; the compute stage still drains into it once it frees, and
// o_in_stall rises only when the compute stage cannot move on.
module laplacian_filter_mirrored_borders_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lap_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lap_pkg::t_out_beat            o_out_beat,
    input  logic                          i_cfg_we,
    input  lap_pkg::t_cfg_reg             i_cfg_index,
    input  logic [lap_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import lap_pkg::*;

    // Configuration.
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;
    logic [DIM_BITS-1:0] w_eff;
    logic [DIM_BITS-1:0] h_eff;

    // Scan state.
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_dcol, n_dcol;
    logic [ROW_BITS-1:0] r_drow, n_drow;
    logic                r_pending, n_pending;
    logic [PIXEL_BITS-1:0] r_prev;

    // Compute stage.
    logic                  r_s1_valid;
    logic                  r_s1_pixel;
    logic                  r_s1_produce;
    logic [PIXEL_BITS-1:0] r_s1_cur;
    logic [COL_BITS-1:0]   r_s1_x;
    logic [ROW_BITS-1:0]   r_s1_y;
    logic                  r_s1_u_older;
    logic                  r_s1_l_prev;
    logic                  r_s1_r_ok;
    logic                  r_s1_last;

    // Forwarding of the write that coincided with this stage's read.
    logic                  r_fwd_c;
    logic                  r_fwd_r;
    logic                  r_fwd_u;
    logic [PIXEL_BITS-1:0] r_fwd_newer;
    logic [PIXEL_BITS-1:0] r_fwd_older;

    // Output register.
    logic      r_out_valid;
    t_out_beat r_out;

    // Stage-0 decode.
    logic                accept;
    logic                is_pixel;
    logic [COL_BITS-1:0] rd_x;
    logic [DIM_BITS-1:0] rd_x_p1;
    logic                enter_s1;
    logic                s0_produce;
    logic [ROW_BITS-1:0] s0_y;
    logic                s0_u_older;
    logic                s0_last;

    logic out_free;
    logic s1_adv;

    t_ls_rd                ls_rd;
    t_ls_wr                ls_wr;
    logic [PIXEL_BITS-1:0] mem_c;
    logic [PIXEL_BITS-1:0] mem_r;
    logic [PIXEL_BITS-1:0] mem_u;

    logic [PIXEL_BITS-1:0] c_val;
    logic [PIXEL_BITS-1:0] r_nb;
    logic [PIXEL_BITS-1:0] u_old;
    logic signed [PIXEL_BITS-1:0] c_s, l_s, r_s, u_s, d_s;
    logic signed [LAP_BITS-1:0]   lap_sum;

    // Width or height 0 acts as 1; above MAX_WIDTH or HEIGHT_LIMIT, as that limit.
    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_BITS'(1);
        end else if (r_width > DIM_BITS'(MAX_WIDTH)) begin
            w_eff = DIM_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_BITS'(1);
        end else if (r_height > DIM_BITS'(HEIGHT_LIMIT)) begin
            h_eff = DIM_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default:          r_width  <= r_width;
            endcase
        end
    end

    // Handshake. The compute stage moves on when it has no result to deliver
    // or the output register is free or being emptied in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (!r_s1_produce || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_pixel   = (i_in_beat.cmd == CMD_PIXEL);

    // Stage 0: decode the beat against the scan counters and advance them.
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_dcol     = r_dcol;
        n_drow     = r_drow;
        n_pending  = r_pending;
        rd_x       = is_pixel ? r_col : r_dcol;
        rd_x_p1    = DIM_BITS'(rd_x) + DIM_BITS'(1);
        s0_last    = (rd_x_p1 >= w_eff);
        enter_s1   = 1'b0;
        s0_produce = 1'b0;
        s0_y       = r_drow;
        s0_u_older = 1'b0;
        if (is_pixel) begin
            enter_s1   = 1'b1;
            s0_produce = (r_row != '0);
            s0_y       = r_row - ROW_BITS'(1);
            s0_u_older = (r_row > ROW_BITS'(1));
            n_pending  = 1'b0;
            if (s0_last) begin
                n_col = '0;
                if ((DIM_BITS'(r_row) + DIM_BITS'(1)) >= h_eff) begin
                    n_row     = '0;
                    n_pending = 1'b1;
                    n_dcol    = '0;
                    n_drow    = r_row;
                end else begin
                    n_row = r_row + ROW_BITS'(1);
                end
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end else if (r_pending) begin
            enter_s1   = 1'b1;
            s0_produce = 1'b1;
            s0_y       = r_drow;
            s0_u_older = (r_drow != '0);
            if (s0_last) begin
                n_pending = 1'b0;
                n_dcol    = '0;
            end else begin
                n_dcol = r_dcol + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_dcol    <= '0;
            r_drow    <= '0;
            r_pending <= 1'b0;
        end else if (accept) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_dcol    <= n_dcol;
            r_drow    <= n_drow;
            r_pending <= n_pending;
        end
    end

    // Line stores: read at accept, write back when the compute stage moves on with a pixel.
    assign ls_rd.en   = accept;
    assign ls_rd.addr = rd_x;
    assign ls_wr.we   = s1_adv && r_s1_pixel;
    assign ls_wr.addr = r_s1_x;
    assign ls_wr.newer = r_s1_cur;
    assign ls_wr.older = c_val;

    lap_line_store u_line_store (
        .i_clk    (i_clk),
        .i_rd     (ls_rd),
        .i_wr     (ls_wr),
        .o_center (mem_c),
        .o_right  (mem_r),
        .o_up     (mem_u)
    );

    // Stage 1 registers. A read that lands in the same edge as a write to the
    // same column sees old data, so the written values are kept for forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_c    <= 1'b0;
            r_fwd_r    <= 1'b0;
            r_fwd_u    <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= enter_s1;
                r_fwd_c    <= ls_wr.we && (r_s1_x == rd_x);
                r_fwd_u    <= ls_wr.we && (r_s1_x == rd_x);
                r_fwd_r    <= ls_wr.we && (r_s1_x == rd_x_p1[COL_BITS-1:0]);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel   <= is_pixel;
            r_s1_produce <= s0_produce;
            r_s1_cur     <= i_in_beat.pixel_value;
            r_s1_x       <= rd_x;
            r_s1_y       <= s0_y;
            r_s1_u_older <= s0_u_older;
            r_s1_l_prev  <= (rd_x != '0);
            r_s1_r_ok    <= (rd_x_p1 < w_eff);
            r_s1_last    <= s0_last && !is_pixel;
            r_fwd_newer  <= r_s1_cur;
            r_fwd_older  <= c_val;
        end
    end

    // The center of the previous item is the left neighbor of the next one,
    // for pixels and for drains alike.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (s1_adv) begin
            r_prev <= c_val;
        end
    end

    // Stage 1: neighbor selection with edge mirroring and the sum.
    always_comb begin
        c_val = r_fwd_c ? r_fwd_newer : mem_c;
        r_nb  = r_fwd_r ? r_fwd_newer : mem_r;
        u_old = r_fwd_u ? r_fwd_older : mem_u;
        c_s   = c_val;
        u_s   = r_s1_u_older ? u_old : c_val;
        l_s   = r_s1_l_prev ? r_prev : c_val;
        r_s   = r_s1_r_ok ? r_nb : c_val;
        d_s   = r_s1_pixel ? r_s1_cur : c_val;
        lap_sum = LAP_BITS'(l_s) + LAP_BITS'(r_s) + LAP_BITS'(u_s) + LAP_BITS'(d_s)
                  - (LAP_BITS'(c_s) <<< 2);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_produce) begin
            r_out.laplace_value <= lap_sum;
            r_out.column        <= r_s1_x;
            r_out.row           <= r_s1_y;
            r_out.frame_end     <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule
